[rtl/msbs_pkg.sv]
package msbs_pkg;

    // pattern store size and field widths
    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int SEEN_W      = 33;
    localparam int ADDR_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // input item kind
    typedef enum logic
    {
        MODE_PATTERN = 1'b0,
        MODE_BYTE    = 1'b1
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_BASE_ADDRESS   = 2'd0,
        CFG_SCAN_LENGTH    = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    // control from the top level to the matcher
    typedef struct packed
    {
        logic             write;
        logic             step;
        logic [IDX_W-1:0] entry_index;
        logic             care;
    } msbs_ctl_t;

endpackage

[rtl/msbs_if.sv]
interface msbs_in_if;
    import msbs_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [BYTE_W-1:0] byte_value;
    logic              care;
    modport source (output valid, mode, entry_index, byte_value, care, input ready);
    modport sink (input valid, mode, entry_index, byte_value, care, output ready);
endinterface

interface msbs_out_if;
    import msbs_pkg::*;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;
    modport source (output valid, found, match_address, input ready);
    modport sink (input valid, found, match_address, output ready);
endinterface

interface msbs_cfg_if;
    import msbs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/msbs_matcher.sv]
module msbs_matcher
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  msbs_pkg::msbs_ctl_t           ctl,
    input  logic [msbs_pkg::BYTE_W-1:0]   byte_value,
    input  logic [msbs_pkg::IDX_W-1:0]    len_m1,
    output logic                          hit
);
    import msbs_pkg::*;

    logic [BYTE_W-1:0]      pat_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care_reg;
    logic [MAX_PATTERN-1:0] prefix_reg;
    logic [MAX_PATTERN-1:0] prefix_next;
    logic [MAX_PATTERN-1:0] pos_ok;

    // pattern bytes, written one entry per pattern request
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            pat_mem[ctl.entry_index] <= byte_value;
        end
    end

    // care bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            care_reg <= '0;
        end
        else if (ctl.write)
        begin
            care_reg[ctl.entry_index] <= ctl.care;
        end
    end

    // per-position compare of the incoming byte
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pos_ok[j] = !care_reg[j] || (pat_mem[j] == byte_value);
        end
    end

    // prefix j set when pattern entries 0..j match the bytes ending here
    always_comb
    begin
        prefix_next = {prefix_reg[MAX_PATTERN-2:0], 1'b1} & pos_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
        end
        else if (ctl.write)
        begin
            prefix_reg <= '0;
        end
        else if (ctl.step)
        begin
            prefix_reg <= prefix_next;
        end
    end

    // full pattern match at the active length
    assign hit = prefix_next[len_m1];

endmodule

[rtl/masked_byte_signature_scan.sv]
// Masked byte pattern search. Pattern requests (mode 0) load one entry with
// its value and care bit and restart the scan; byte requests (mode 1) stream
// memory bytes starting at base_address. One result is given per scan: the
// first start offset below scan_length where every cared-for pattern byte
// matches (found set, address base_address plus offset), or found clear with
// an all-ones address once scan_length offsets were tried. Further bytes are
// dropped until the next pattern request. A request is held in the input
// register until the result register can take a result; a result that it
// causes is then loaded into the result register, where it is held until
// it is taken. A request is taken in every cycle while results are drained,
// and the matcher keeps a prefix-match bit per pattern position, so the
// compare depth does not depend on length.
// The user must write configuration only while no request is in flight;
// the block does not enforce it.
module masked_byte_signature_scan
(
    input  logic       clk,
    input  logic       rst_n,
    msbs_cfg_if.sink   cfg,
    msbs_in_if.sink    item,
    msbs_out_if.source result
);
    import msbs_pkg::*;

    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    scan_reg;
    logic [LEN_W-1:0]     plen_reg;

    logic                 s1_valid_reg;
    logic                 s1_mode_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic [BYTE_W-1:0]    s1_byte_reg;
    logic                 s1_care_reg;

    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic                 finished_reg;

    logic                 out_valid_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    addr_reg;

    logic                 advance;
    logic                 step;
    logic                 is_pattern;
    logic                 hit;
    logic                 enough;
    logic [SEEN_W-1:0]    offset;
    logic                 in_range;
    logic                 match_now;
    logic                 end_now;
    logic                 out_load;
    logic [IDX_W-1:0]     len_m1;
    logic [LEN_W-1:0]     eff_len;
    msbs_ctl_t            ctl;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            scan_reg <= '0;
            plen_reg <= LEN_W'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BASE_ADDRESS:   base_reg <= cfg.data;
                CFG_SCAN_LENGTH:    scan_reg <= cfg.data;
                CFG_PATTERN_LENGTH: plen_reg <= cfg.data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective pattern length, clamped to 1..MAX_PATTERN
    always_comb
    begin
        priority if (plen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (plen_reg > LEN_W'(MAX_PATTERN))
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = plen_reg;
        end
    end

    assign len_m1 = IDX_W'(eff_len - LEN_W'(1));

    // input register moves on when the result register can take a result
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign is_pattern = (s1_mode_reg == MODE_PATTERN);
    assign step       = advance && !is_pattern && !finished_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_mode_reg <= item.mode;
            s1_idx_reg  <= item.entry_index;
            s1_byte_reg <= item.byte_value;
            s1_care_reg <= item.care;
        end
    end

    // matcher control
    always_comb
    begin
        ctl.write       = advance && is_pattern;
        ctl.step        = step;
        ctl.entry_index = s1_idx_reg;
        ctl.care        = s1_care_reg;
    end

    msbs_matcher u_matcher
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .byte_value (s1_byte_reg),
        .len_m1     (len_m1),
        .hit        (hit)
    );

    // byte count with saturation, candidate offset and end test
    assign seen_next = (&seen_reg) ? seen_reg : seen_reg + SEEN_W'(1);
    assign enough    = seen_next >= SEEN_W'(eff_len);
    assign offset    = seen_next - SEEN_W'(eff_len);
    assign in_range  = offset < SEEN_W'(scan_reg);
    assign match_now = enough && in_range && hit;
    assign end_now   = (scan_reg == '0)
                       || (enough && (offset + SEEN_W'(1) >= SEEN_W'(scan_reg)));
    assign out_load  = step && (match_now || end_now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else if (ctl.write)
        begin
            seen_reg     <= '0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            seen_reg     <= seen_next;
            finished_reg <= match_now || end_now;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg <= match_now;
            addr_reg  <= match_now ? base_reg + offset[ADDR_W-1:0] : '1;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = found_reg;
    assign result.match_address = addr_reg;

`ifndef ASSERT_OFF
    // a finished scan gives no further result
    a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !finished_reg)
        else $error("result produced after scan end");

    // a result always ends the scan
    a_result_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> finished_reg)
        else $error("scan not ended after result");

    // a pattern request restarts the scan
    a_pattern_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.write |=> (seen_reg == '0) && !finished_reg)
        else $error("pattern request did not restart scan");

    // not-found results carry an all-ones address
    a_not_found_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (&addr_reg))
        else $error("not-found result without all-ones address");

    // a result is only loaded when the register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten");
`endif

endmodule
